// ----- sv/fbfp_pkg.sv -----
// shared constants and request codes for the monochrome framebuffer fill block
package fbfp_pkg;

	// request kinds, also echoed on done_kind
	localparam logic [1:0] REQ_FILL  = 2'd0;
	localparam logic [1:0] REQ_CLEAR = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;
	localparam logic [1:0] REQ_NONE  = 2'd3;

	// field widths
	localparam int REQ_W   = 2;
	localparam int COORD_W = 9;
	localparam int SIZE_W  = 8;
	localparam int INDEX_W = 10;
	localparam int BYTE_W  = 8;

	// pixels packed into one display byte
	localparam int GROUP_BITS = 8;

	// default frame size
	localparam int DEF_FB_WIDTH  = 64;
	localparam int DEF_FB_HEIGHT = 128;

endpackage

// ----- sv/fbfp_ram.sv -----
// generic single write port ram with registered read
module fbfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- sv/mono_framebuffer_fill_pack.sv -----
// monochrome framebuffer with rectangle fill, clear and packed byte read
//
//  channel   direction  handshake            payload
//  request   in         start high, busy low req_type rect_x rect_y rect_w rect_h
//                                            fill_value read_index
//  result    out        done, one cycle      done_kind read_data
//
// sequence: a fill clips in a setup state, then makes one read and one write of the
//   shared pixel ram per byte group; a read takes the registered ram byte; clear
//   writes every byte (one ram write a cycle); an unused kind is taken and dropped
// reset: a clearing pass over all STORE_BYTES bytes (1024 by default) zeroes the ram,
//   busy stays high through it
// stalls: the receiver cannot stall, done pulses for one cycle per result
module mono_framebuffer_fill_pack #(
	parameter int FB_WIDTH  = fbfp_pkg::DEF_FB_WIDTH,
	parameter int FB_HEIGHT = fbfp_pkg::DEF_FB_HEIGHT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [fbfp_pkg::REQ_W-1:0]        req_type,
	input  logic signed [fbfp_pkg::COORD_W-1:0] rect_x,
	input  logic signed [fbfp_pkg::COORD_W-1:0] rect_y,
	input  logic [fbfp_pkg::SIZE_W-1:0]       rect_w,
	input  logic [fbfp_pkg::SIZE_W-1:0]       rect_h,
	input  logic                              fill_value,
	input  logic [fbfp_pkg::INDEX_W-1:0]      read_index,
	output logic                              done,
	output logic [fbfp_pkg::REQ_W-1:0]        done_kind,
	output logic [fbfp_pkg::BYTE_W-1:0]       read_data
);

	import fbfp_pkg::*;

	// frame geometry
	localparam int GROUPS      = (FB_WIDTH + GROUP_BITS - 1) / GROUP_BITS;
	localparam int STORE_BYTES = GROUPS * FB_HEIGHT;
	localparam int AW          = $clog2(STORE_BYTES);
	localparam int GW          = (GROUPS > 1) ? $clog2(GROUPS) : 1;
	localparam int RW          = $clog2(FB_HEIGHT);
	localparam int RW1         = $clog2(FB_HEIGHT + 1);
	localparam int SW          = 11;   // signed width for clipping math
	localparam int EW          = 14;   // holds read_index and STORE_BYTES

	localparam logic signed [SW-1:0] W_S  = SW'(FB_WIDTH);
	localparam logic signed [SW-1:0] H_S  = SW'(FB_HEIGHT);
	localparam logic [AW-1:0]        LAST = AW'(STORE_BYTES - 1);
	localparam logic [EW-1:0]        SB_E = EW'(STORE_BYTES);

	// sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CLR   = 3'd1;
	localparam logic [2:0] ST_SETUP = 3'd2;
	localparam logic [2:0] ST_FRD   = 3'd3;
	localparam logic [2:0] ST_FWR   = 3'd4;
	localparam logic [2:0] ST_RD    = 3'd5;
	localparam logic [2:0] ST_RDW   = 3'd6;

	logic [2:0] state_q;

	// latched request
	logic signed [COORD_W-1:0]   x_q;
	logic signed [COORD_W-1:0]   y_in_q;
	logic [SIZE_W-1:0]           w_q;
	logic [SIZE_W-1:0]           h_q;
	logic                        fval_q;
	logic                        rd_ok_q;
	logic                        clr_res_q;

	// fill walk
	logic [RW-1:0]  row_q;
	logic [RW1-1:0] row_end_q;
	logic [GW-1:0]  g_q;
	logic [GW-1:0]  g_lo_q;
	logic [GW-1:0]  g_hi_q;
	logic [2:0]     lo_bit_q;
	logic [2:0]     hi_bit_q;

	// ram address register: sweep counter, read index or fill write address
	logic [AW-1:0] addr_q;

	// result registers
	logic             done_q;
	logic [REQ_W-1:0] done_kind_q;
	logic [BYTE_W-1:0] read_data_q;

	// ram ports
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [BYTE_W-1:0] ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [BYTE_W-1:0] ram_rdata;

	// clipping of the rectangle to the frame
	logic signed [SW-1:0] xs, ys, x1, y1, x0c, y0c, x1c, y1c, m_lo, m_hi;
	logic                 fill_empty;
	logic [EW-1:0]        idx_ext;

	always_comb begin
		xs  = SW'(x_q);
		ys  = SW'(y_in_q);
		x1  = xs + $signed({3'b000, w_q});
		y1  = ys + $signed({3'b000, h_q});
		x0c = (xs < 0) ? '0 : xs;
		y0c = (ys < 0) ? '0 : ys;
		x1c = (x1 > W_S) ? W_S : x1;
		y1c = (y1 > H_S) ? H_S : y1;
		fill_empty = (x1c <= x0c) || (y1c <= y0c);
		// mirrored column range covered by the rectangle
		m_lo = W_S - x1c;
		m_hi = W_S - SW'(1) - x0c;
	end

	assign idx_ext = EW'(read_index);

	// shared address unit: group times frame height plus row
	logic [AW-1:0] addr_calc;
	assign addr_calc = AW'(AW'(g_q) * AW'(FB_HEIGHT)) + AW'(row_q);

	// bit mask of the current byte group inside the column range
	logic [2:0]        lo_b, hi_b;
	logic [BYTE_W-1:0] mask;
	always_comb begin
		lo_b = (g_q == g_lo_q) ? lo_bit_q : 3'd0;
		hi_b = (g_q == g_hi_q) ? hi_bit_q : 3'd7;
		mask = (8'hFF << lo_b) & (8'hFF >> (3'd7 - hi_b));
	end

	// ram port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = '0;
		ram_raddr = addr_calc;
		unique case (state_q)
			ST_CLR: begin
				ram_we = 1'b1;
			end
			ST_FWR: begin
				ram_we    = 1'b1;
				ram_wdata = fval_q ? (ram_rdata | mask) : (ram_rdata & ~mask);
			end
			ST_RD: begin
				ram_raddr = addr_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	fbfp_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(STORE_BYTES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;   // clearing pass after reset
			addr_q      <= '0;
			clr_res_q   <= 1'b0;
			done_q      <= 1'b0;
			done_kind_q <= '0;
			read_data_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					done_q <= 1'b0;
					if (start) begin
						x_q    <= rect_x;
						y_in_q <= rect_y;
						w_q    <= rect_w;
						h_q    <= rect_h;
						fval_q <= fill_value;
						unique case (req_type)
							REQ_FILL: begin
								state_q <= ST_SETUP;
							end
							REQ_CLEAR: begin
								addr_q    <= '0;
								clr_res_q <= 1'b1;
								state_q   <= ST_CLR;
							end
							REQ_READ: begin
								addr_q  <= idx_ext[AW-1:0];
								rd_ok_q <= idx_ext < SB_E;
								state_q <= ST_RD;
							end
							default: begin
								state_q <= ST_IDLE;   // unused kind is dropped
							end
						endcase
					end
				end
				ST_CLR: begin
					addr_q <= addr_q + AW'(1);
					if (addr_q == LAST) begin
						state_q <= ST_IDLE;
						done_q  <= clr_res_q;
						if (clr_res_q) begin
							done_kind_q <= REQ_CLEAR;
							read_data_q <= '0;
						end
						clr_res_q <= 1'b0;
					end else begin
						done_q <= 1'b0;
					end
				end
				ST_SETUP: begin
					row_q     <= y0c[RW-1:0];
					row_end_q <= y1c[RW1-1:0];
					g_lo_q    <= GW'(m_lo >>> 3);
					g_hi_q    <= GW'(m_hi >>> 3);
					g_q       <= GW'(m_lo >>> 3);
					lo_bit_q  <= m_lo[2:0];
					hi_bit_q  <= m_hi[2:0];
					done_q    <= fill_empty;
					if (fill_empty) begin
						state_q     <= ST_IDLE;
						done_kind_q <= REQ_FILL;
						read_data_q <= '0;
					end else begin
						state_q <= ST_FRD;
					end
				end
				ST_FRD: begin
					done_q  <= 1'b0;
					addr_q  <= addr_calc;
					state_q <= ST_FWR;
				end
				ST_FWR: begin
					if (g_q == g_hi_q) begin
						g_q <= g_lo_q;
						if (RW1'(row_q) + RW1'(1) == row_end_q) begin
							state_q     <= ST_IDLE;
							done_q      <= 1'b1;
							done_kind_q <= REQ_FILL;
							read_data_q <= '0;
						end else begin
							state_q <= ST_FRD;
							done_q  <= 1'b0;
							row_q   <= row_q + RW'(1);
						end
					end else begin
						state_q <= ST_FRD;
						done_q  <= 1'b0;
						g_q     <= g_q + GW'(1);
					end
				end
				ST_RD: begin
					done_q  <= 1'b0;
					state_q <= ST_RDW;
				end
				ST_RDW: begin
					state_q     <= ST_IDLE;
					done_q      <= 1'b1;
					done_kind_q <= REQ_READ;
					read_data_q <= rd_ok_q ? ram_rdata : '0;
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign done_kind = done_kind_q;
	assign read_data = read_data_q;

`ifndef SYNTHESIS
	// a result only ever closes a request that kept the block busy
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without preceding work");

	// only a read returns a nonzero byte
	a_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		(done && done_kind != REQ_READ) |-> read_data == '0)
		else $error("nonzero data on fill or clear result");

	// a valid request always starts work
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req_type != REQ_NONE) |=> busy)
		else $error("accepted request did not start work");

	// the group walk stays inside the clipped column range
	a_group_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FWR) |-> (g_q >= g_lo_q && g_q <= g_hi_q))
		else $error("byte group outside the rectangle");
`endif

endmodule

// ----- tb/tb.sv -----
// testbench for the framebuffer fill block, directed table then random items vs a shadow image
module tb;
	import fbfp_pkg::*;

	// frame geometry mirrored from the block defaults
	localparam int FB_W        = DEF_FB_WIDTH;
	localparam int FB_H        = DEF_FB_HEIGHT;
	localparam int GROUPS      = (FB_W + GROUP_BITS - 1) / GROUP_BITS;
	localparam int STORE_BYTES = GROUPS * FB_H;
	// a full-frame fill and a clear each walk the whole store, plus the clearing pass
	// after reset and sender gaps; the limit takes all of that several times over
	localparam int CYCLE_LIMIT = 10000000;
	localparam int ITEMS_PER_PHASE = 300;

	typedef struct {
		logic [REQ_W-1:0]  kind;
		logic [BYTE_W-1:0] data;
	} fb_result_t;

	// one row of the directed table; typed rows carry the read byte to expect
	typedef struct {
		logic [REQ_W-1:0] kind;
		int               x;
		int               y;
		int               w;
		int               h;
		logic             val;
		int               idx;
		bit               typed;
		logic [BYTE_W-1:0] byte_val;
	} fb_stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic [REQ_W-1:0] req_type;
	logic signed [COORD_W-1:0] rect_x;
	logic signed [COORD_W-1:0] rect_y;
	logic [SIZE_W-1:0] rect_w;
	logic [SIZE_W-1:0] rect_h;
	logic fill_value;
	logic [INDEX_W-1:0] read_index;
	logic done;
	logic [REQ_W-1:0] done_kind;
	logic [BYTE_W-1:0] read_data;

	// shadow copy of the packed display bytes
	logic [BYTE_W-1:0] shadow_fb [0:STORE_BYTES-1];
	fb_result_t pending_results [$];
	int error_count = 0;
	int cycle_count = 0;

	// override of the predicted read byte for typed directed rows
	bit typed_on = 1'b0;
	logic [BYTE_W-1:0] typed_byte = '0;

	// last fill, so that random reads often land on freshly drawn pixels
	int last_x = 0;
	int last_y = 0;
	int last_w = 0;
	int last_h = 0;

	int idle_pct = 0;
	int idle_by_phase [3] = '{28, 75, 0};

	fb_stim_row_t directed_rows [21] = '{
		// fresh after reset: both ends of the store read zero
		'{REQ_READ,     0,    0,   0,   0, 1'b0,    0, 1'b1, 8'h00},
		'{REQ_READ,     0,    0,   0,   0, 1'b1, 1023, 1'b1, 8'h00},
		// full frame set
		'{REQ_FILL,     0,    0,  64, 128, 1'b1,    0, 1'b0, 8'h00},
		'{REQ_READ,     0,    0,   0,   0, 1'b0,    0, 1'b1, 8'hff},
		'{REQ_READ,     0,    0,   0,   0, 1'b0, 1023, 1'b1, 8'hff},
		// wholly outside, most negative and most positive corners
		'{REQ_FILL,  -256, -256, 255, 255, 1'b0,    0, 1'b0, 8'h00},
		'{REQ_FILL,   255,  255, 255, 255, 1'b0,    0, 1'b0, 8'h00},
		'{REQ_READ,     0,    0,   0,   0, 1'b0,  896, 1'b1, 8'hff},
		// clipped at top left
		'{REQ_FILL,    -5,   -5,  10,  10, 1'b0,    0, 1'b0, 8'h00},
		'{REQ_READ,     0,    0,   0,   0, 1'b0,  896, 1'b0, 8'h00},
		// zero width and zero height draw nothing
		'{REQ_FILL,    20,   20,   0,   5, 1'b0,    0, 1'b0, 8'h00},
		'{REQ_FILL,    10,   10,   5,   0, 1'b0,    0, 1'b0, 8'h00},
		'{REQ_CLEAR,    0,    0,   0,   0, 1'b0,    0, 1'b1, 8'h00},
		'{REQ_READ,     0,    0,   0,   0, 1'b0,    5, 1'b1, 8'h00},
		// unused kind, taken but no result
		'{REQ_NONE,    -1,   -1, 255, 255, 1'b1, 1023, 1'b0, 8'h00},
		// bottom right pixel only, clipped at right and bottom
		'{REQ_FILL,    63,  127, 255, 255, 1'b1,    0, 1'b0, 8'h00},
		'{REQ_READ,     0,    0,   0,   0, 1'b0,  127, 1'b1, 8'h01},
		// top left pixel lands in the last group, top bit
		'{REQ_FILL,     0,    0,   1,   1, 1'b1,    0, 1'b0, 8'h00},
		'{REQ_READ,     0,    0,   0,   0, 1'b0,  896, 1'b1, 8'h80},
		'{REQ_FILL,    -1,    0,   2,   1, 1'b0,    0, 1'b0, 8'h00},
		'{REQ_READ,     0,    0,   0,   0, 1'b0,  896, 1'b1, 8'h00}
	};

	mono_framebuffer_fill_pack dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.rect_x     (rect_x),
		.rect_y     (rect_y),
		.rect_w     (rect_w),
		.rect_h     (rect_h),
		.fill_value (fill_value),
		.read_index (read_index),
		.done       (done),
		.done_kind  (done_kind),
		.read_data  (read_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// write val into every in-frame pixel of the rectangle
	function automatic void shadow_fill(int x, int y, int w, int h, logic val);
		int x0;
		int y0;
		int x1;
		int y1;
		int m;
		int idx;
		x0 = (x < 0) ? 0 : x;
		y0 = (y < 0) ? 0 : y;
		x1 = (x + w > FB_W) ? FB_W : x + w;
		y1 = (y + h > FB_H) ? FB_H : y + h;
		for (int cy = y0; cy < y1; cy++) begin
			for (int cx = x0; cx < x1; cx++) begin
				// columns are mirrored before packing
				m = FB_W - 1 - cx;
				idx = (m / GROUP_BITS) * FB_H + cy;
				shadow_fb[idx][m % GROUP_BITS] = val;
			end
		end
	endfunction

	// apply one accepted item to the shadow image and give its result
	function automatic fb_result_t predict_result(logic [REQ_W-1:0] kind, int x, int y, int w,
			int h, logic val, int idx);
		fb_result_t res;
		res.kind = kind;
		res.data = '0;
		case (kind)
			REQ_FILL: begin
				shadow_fill(x, y, w, h, val);
			end
			REQ_CLEAR: begin
				foreach (shadow_fb[i]) shadow_fb[i] = '0;
			end
			REQ_READ: begin
				if (idx < STORE_BYTES) res.data = shadow_fb[idx];
			end
			default: ;
		endcase
		return res;
	endfunction

	// result check first, then the item accepted at this edge
	always @(posedge clk) begin
		fb_result_t want;
		fb_result_t got;
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
			$display("FAILED: results differ");
			$finish;
		end else if (arst_n === 1'b1) begin
			if (done === 1'b1) begin
				if (pending_results.size() == 0) begin
					error_count++;
					$display("%0t: expected no result, actual kind %0d data %02h",
						$time, done_kind, read_data);
				end else begin
					want = pending_results.pop_front();
					if (done_kind !== want.kind) begin
						error_count++;
						$display("%0t: done_kind expected %0d actual %0d",
							$time, want.kind, done_kind);
					end
					if (read_data !== want.data) begin
						error_count++;
						$display("%0t: read_data expected %02h actual %02h",
							$time, want.data, read_data);
					end
				end
			end
			if (start === 1'b1 && busy === 1'b0) begin
				got = predict_result(req_type, int'(rect_x), int'(rect_y), int'(rect_w),
					int'(rect_h), fill_value, int'(read_index));
				if (typed_on) got.data = typed_byte;
				// the unused kind is taken without a result
				if (req_type != REQ_NONE) pending_results.push_back(got);
			end
		end
	end

	// entered at a falling edge; returns at the falling edge after acceptance
	task automatic send_item(logic [REQ_W-1:0] kind, int x, int y, int w, int h, logic val,
			int idx, bit typed, logic [BYTE_W-1:0] byte_val);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		req_type   = kind;
		rect_x     = x[COORD_W-1:0];
		rect_y     = y[COORD_W-1:0];
		rect_w     = w[SIZE_W-1:0];
		rect_h     = h[SIZE_W-1:0];
		fill_value = val;
		read_index = idx[INDEX_W-1:0];
		typed_on   = typed;
		typed_byte = byte_val;
		start      = 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		@(negedge clk);
	endtask

	// hold off until every result is in and the block is idle
	task automatic drain();
		start = 1'b0;
		while (pending_results.size() != 0 || busy !== 1'b0) @(negedge clk);
	endtask

	task automatic random_item();
		int pick;
		int shape;
		int x;
		int y;
		int w;
		int h;
		int px;
		int py;
		int idx;
		pick = $urandom_range(99);
		x = 0;
		y = 0;
		w = 0;
		h = 0;
		idx = $urandom_range(1023);
		if (pick < 50) begin
			shape = $urandom_range(99);
			if (shape < 75) begin
				// small rectangles around the frame, edges included
				x = $urandom_range(78) - 8;
				y = $urandom_range(143) - 8;
				w = $urandom_range(12);
				h = $urandom_range(12);
			end else if (shape < 90) begin
				x = $urandom_range(103) - 40;
				y = $urandom_range(167) - 40;
				w = $urandom_range(100, 16);
				h = $urandom_range(160, 16);
			end else begin
				// whole field ranges, mostly off frame
				x = $urandom_range(511) - 256;
				y = $urandom_range(511) - 256;
				w = $urandom_range(255);
				h = $urandom_range(255);
			end
			last_x = x;
			last_y = y;
			last_w = w;
			last_h = h;
			send_item(REQ_FILL, x, y, w, h, 1'($urandom_range(1)), idx, 1'b0, 8'h00);
		end else if (pick < 93) begin
			if ($urandom_range(1) == 1) begin
				// aim at a pixel of the latest rectangle
				px = last_x + $urandom_range(last_w);
				py = last_y + $urandom_range(last_h);
				if (px >= 0 && px < FB_W && py >= 0 && py < FB_H)
					idx = ((FB_W - 1 - px) / GROUP_BITS) * FB_H + py;
			end
			send_item(REQ_READ, $urandom_range(511), $urandom_range(511), $urandom_range(255),
				$urandom_range(255), 1'($urandom_range(1)), idx, 1'b0, 8'h00);
		end else if (pick < 96) begin
			send_item(REQ_CLEAR, $urandom_range(511), $urandom_range(511), $urandom_range(255),
				$urandom_range(255), 1'($urandom_range(1)), idx, 1'b0, 8'h00);
		end else begin
			send_item(REQ_NONE, $urandom_range(511), $urandom_range(511), $urandom_range(255),
				$urandom_range(255), 1'($urandom_range(1)), idx, 1'b0, 8'h00);
		end
	endtask

	initial begin
		foreach (shadow_fb[i]) shadow_fb[i] = '0;
		arst_n     = 1'b0;
		start      = 1'b0;
		req_type   = REQ_FILL;
		rect_x     = '0;
		rect_y     = '0;
		rect_w     = '0;
		rect_h     = '0;
		fill_value = 1'b0;
		read_index = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// directed table, sent back to back; the clearing pass holds the first one
		idle_pct = 0;
		foreach (directed_rows[i])
			send_item(directed_rows[i].kind, directed_rows[i].x, directed_rows[i].y,
				directed_rows[i].w, directed_rows[i].h, directed_rows[i].val,
				directed_rows[i].idx, directed_rows[i].typed, directed_rows[i].byte_val);
		drain();

		// random phases with different sender gaps, each drained before the next
		for (int p = 0; p < 3; p++) begin
			idle_pct = idle_by_phase[p];
			repeat (ITEMS_PER_PHASE) random_item();
			drain();
		end

		// an unused kind never makes the block busy; watch for stray results
		repeat (64) @(posedge clk);
		if (error_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
